// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Command codes, controller states and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Operation codes carried on the request side
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_LOOK       = 3'd4
	} dq_cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,  // waiting for a request
		ST_FILL = 2'd1,  // end-word cache reload from the store
		ST_OUT  = 2'd2   // result held until taken
	} dq_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;    // apply the incoming request
		logic refill;  // load the store read data into the end-word cache
	} dq_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic need_fill;  // incoming request is a pop that removes a word
	} dq_sts_t;

endpackage

// File: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words in a ring store
//
//   channel  dir  tdata (low bit up)                          tuser
//   s_*      in   push_value[31:0]                            cmd[2:0]
//   m_*      out  popped_value, front_value, back_value,      popped_valid,
//                 element_count (zero padded to bytes)        is_empty, overflow
//
// A result shows in the cycle after its request is accepted, except for a pop that
// removes a word: that request first passes through the fill state, where the
// registered store read reloads the end-word cache. One request is in flight;
// the next is accepted in the cycle after the result is taken, so stalls on
// the output hold the input side.
// Reset sets pointers to an empty ring and clears count, flags and control; the store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = 1024,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OW = ((96 + CW + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // push_value
	input  logic [2:0]    s_tuser,   // cmd
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [OW-1:0] m_tdata,   // popped_value, front_value, back_value, element_count
	output logic [2:0]    m_tuser    // popped_valid, is_empty, overflow
);
	import dq_pkg::*;

	dq_ctl_t            ctl;
	dq_sts_t            sts;
	logic signed [31:0] popped_value;
	logic               popped_valid;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [CW-1:0]      element_count;
	logic               is_empty;
	logic               overflow;

	// Sequencer
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Store and state
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (s_tuser),
		.push_value    (s_tdata),
		.popped_value  (popped_value),
		.popped_valid  (popped_valid),
		.front_value   (front_value),
		.back_value    (back_value),
		.element_count (element_count),
		.is_empty      (is_empty),
		.overflow      (overflow)
	);

	// Result packing
	assign m_tdata = OW'({element_count, back_value, front_value, popped_value});
	assign m_tuser = {overflow, is_empty, popped_valid};

endmodule

// File: rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer
// Accepts one request at a time, passes through a fill state for the store read
// after a pop that removes a word, then holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  dq_pkg::dq_sts_t  sts,
	output dq_pkg::dq_ctl_t  ctl
);
	import dq_pkg::*;

	dq_state_t state_q;
	dq_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and outputs
	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		ctl.take   = 1'b0;
		ctl.refill = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take  = 1'b1;
					state_nxt = sts.need_fill ? ST_FILL : ST_OUT;
				end
			end
			ST_FILL: begin
				ctl.refill = 1'b1;
				state_nxt  = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// One request in flight: never accepting while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request accepted while result pending");

	// A removing pop is always followed by a cache reload
	a_fill_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take && sts.need_fill) |=> ctl.refill)
		else $error("missing cache reload after pop");

	// Once the result is taken the block is ready again
	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("not ready after result taken");

endmodule

// File: rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath: ring store, end pointers, count and end-word cache
// The front and back words are cached in registers; the store read data is used
// only to reload an end of the cache after a pop.
// ----------------------------------------------------------------------------
module dq_datapath #(
	parameter int DEPTH = 1024,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dq_pkg::dq_ctl_t    ctl,
	output dq_pkg::dq_sts_t    sts,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] push_value,
	output logic signed [31:0] popped_value,
	output logic               popped_valid,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [CW-1:0]      element_count,
	output logic               is_empty,
	output logic               overflow
);
	import dq_pkg::*;

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_data_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic          wr_en;

	logic [IW-1:0] front_idx_q;
	logic [IW-1:0] back_idx_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   front_word_q;
	logic [31:0]   back_word_q;
	logic [31:0]   popped_q;
	logic          popped_valid_q;
	logic          overflow_q;
	logic          refill_front_q;

	logic [IW-1:0] front_next;
	logic [IW-1:0] front_prev;
	logic [IW-1:0] back_next;
	logic [IW-1:0] back_prev;
	logic          full;
	logic          empty;
	dq_cmd_t       op;

	// Ring pointer neighbors
	assign front_next = (front_idx_q == IW'(DEPTH - 1)) ? '0 : front_idx_q + 1'b1;
	assign front_prev = (front_idx_q == '0) ? IW'(DEPTH - 1) : front_idx_q - 1'b1;
	assign back_next  = (back_idx_q == IW'(DEPTH - 1)) ? '0 : back_idx_q + 1'b1;
	assign back_prev  = (back_idx_q == '0) ? IW'(DEPTH - 1) : back_idx_q - 1'b1;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	// Request decode; unused codes behave as look
	always_comb begin
		case (cmd)
			CMD_PUSH_FRONT: op = CMD_PUSH_FRONT;
			CMD_PUSH_BACK:  op = CMD_PUSH_BACK;
			CMD_POP_FRONT:  op = CMD_POP_FRONT;
			CMD_POP_BACK:   op = CMD_POP_BACK;
			default:        op = CMD_LOOK;
		endcase
	end

	assign sts.need_fill = !empty && (op == CMD_POP_FRONT || op == CMD_POP_BACK);

	// Store port addresses
	assign wr_en   = ctl.take && !full && (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK);
	assign wr_addr = (op == CMD_PUSH_FRONT) ? front_next : back_prev;
	assign rd_addr = (op == CMD_POP_FRONT) ? front_prev : back_next;

	// Ring store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Pointers, count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx_q    <= '0;
			back_idx_q     <= IW'(1);
			cnt_q          <= '0;
			popped_valid_q <= 1'b0;
			overflow_q     <= 1'b0;
			refill_front_q <= 1'b0;
		end else if (ctl.take) begin
			popped_valid_q <= 1'b0;
			overflow_q     <= 1'b0;
			case (op)
				CMD_PUSH_FRONT: begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						front_idx_q <= front_next;
						cnt_q       <= cnt_q + 1'b1;
					end
				end
				CMD_PUSH_BACK: begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						back_idx_q <= back_prev;
						cnt_q      <= cnt_q + 1'b1;
					end
				end
				CMD_POP_FRONT: begin
					if (!empty) begin
						popped_valid_q <= 1'b1;
						front_idx_q    <= front_prev;
						cnt_q          <= cnt_q - 1'b1;
						refill_front_q <= 1'b1;
					end
				end
				CMD_POP_BACK: begin
					if (!empty) begin
						popped_valid_q <= 1'b1;
						back_idx_q     <= back_next;
						cnt_q          <= cnt_q - 1'b1;
						refill_front_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// End-word cache and popped word
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			popped_q <= '0;
			case (op)
				CMD_PUSH_FRONT: begin
					if (!full) begin
						front_word_q <= push_value;
						if (empty) begin
							back_word_q <= push_value;
						end
					end
				end
				CMD_PUSH_BACK: begin
					if (!full) begin
						back_word_q <= push_value;
						if (empty) begin
							front_word_q <= push_value;
						end
					end
				end
				CMD_POP_FRONT: begin
					if (!empty) begin
						popped_q <= front_word_q;
					end
				end
				CMD_POP_BACK: begin
					if (!empty) begin
						popped_q <= back_word_q;
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.refill) begin
			if (refill_front_q) begin
				front_word_q <= rd_data_q;
			end else begin
				back_word_q <= rd_data_q;
			end
		end
	end

	// Result fields
	assign popped_value  = popped_q;
	assign popped_valid  = popped_valid_q;
	assign front_value   = empty ? '0 : front_word_q;
	assign back_value    = empty ? '0 : back_word_q;
	assign element_count = cnt_q;
	assign is_empty      = empty;
	assign overflow      = overflow_q;

	// Count stays within capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("count beyond capacity");

	// Empty ring: back pointer sits one past the front pointer
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (back_idx_q == front_next))
		else $error("pointers inconsistent on empty ring");

	// A result is never both a pop and a dropped push
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(popped_valid_q && overflow_q))
		else $error("pop and overflow flagged together");

endmodule

// File: tb/sv/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the bounded deque
// Drives push, pop and look requests over the input stream with random gaps,
// stalls the result stream at random, and compares every result field by
// field against an in-bench deque that tracks store, end pointers and count.
// Covers the empty and full corners, unused command codes, pointer wrap and
// a long output hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int OW          = ((96 + CW + 7) / 8) * 8;
	localparam int HALF_PERIOD = 6;
	localparam int ITEM_BUDGET = 1250;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 16;

	// unused command codes, expected to act as look
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// one result as seen on the output stream
	typedef struct packed {
		logic [31:0]   popped;
		logic          pvalid;
		logic [31:0]   front;
		logic [31:0]   back;
		logic [CW-1:0] count;
		logic          empty;
		logic          ovf;
	} deque_result_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [31:0]   s_tdata;   // push_value
	logic [2:0]    s_tuser;   // cmd
	logic          m_tvalid;
	logic          m_tready;
	logic [OW-1:0] m_tdata;   // popped_value, front_value, back_value, element_count
	logic [2:0]    m_tuser;   // popped_valid, is_empty, overflow

	// bench copy of the deque
	logic [31:0]   deque_words [DEPTH];
	int            head_pos;
	int            tail_pos;
	int            word_count;

	deque_result_t pending_results [$];

	int            fail_count = 0;
	int            sent_count;
	int            result_count = 0;
	int            popped_count = 0;
	int            overflow_count = 0;
	int            peak_count;
	int            hold_req;
	int            holds_done = 0;
	int            quiet_cycles = 0;
	bit            no_idle;

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// push word: mostly random, sometimes a corner value
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// random end for a push or a pop
	function automatic logic [2:0] pick_push();
		return ($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
	endfunction

	function automatic logic [2:0] pick_pop();
		return ($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK;
	endfunction

	// apply one request to the bench deque and return the result it gives
	function automatic deque_result_t next_deque_result(logic [2:0] op, logic [31:0] value);
		deque_result_t r;
		logic full;
		r = '0;
		full = (word_count >= DEPTH);
		case (op)
			CMD_PUSH_FRONT: begin
				if (full) begin
					r.ovf = 1'b1;
				end else begin
					head_pos = (head_pos + 1) % DEPTH;
					deque_words[head_pos] = value;
					word_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					r.ovf = 1'b1;
				end else begin
					tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
					deque_words[tail_pos] = value;
					word_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (word_count != 0) begin
					r.popped = deque_words[head_pos];
					r.pvalid = 1'b1;
					head_pos = (head_pos + DEPTH - 1) % DEPTH;
					word_count--;
				end
			end
			CMD_POP_BACK: begin
				if (word_count != 0) begin
					r.popped = deque_words[tail_pos];
					r.pvalid = 1'b1;
					tail_pos = (tail_pos + 1) % DEPTH;
					word_count--;
				end
			end
			default: begin
				// look, and the unused codes act as look
			end
		endcase
		if (word_count != 0) begin
			r.front = deque_words[head_pos];
			r.back  = deque_words[tail_pos];
		end
		r.count = CW'(word_count);
		r.empty = (word_count == 0);
		return r;
	endfunction

	// offer one request, wait for the handshake, then record what it should give
	task automatic send_request(logic [2:0] op, logic [31:0] value);
		int gap;
		deque_result_t want;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		want = next_deque_result(op, value);
		pending_results = {pending_results, want};
		sent_count++;
		if (word_count > peak_count)
			peak_count = word_count;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// result stream: random stalls, quiet stretches and a requested long hold-off
	initial begin
		int stall;
		forever begin
			if (holds_done < hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (no_idle) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = gap_len();
				if (stall != 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$error("result with no request pending: tdata %0h tuser %0h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (want.pvalid)
					popped_count++;
				if (want.ovf)
					overflow_count++;
				check_field("popped_value", want.popped, m_tdata[31:0]);
				check_field("popped_valid", 32'(want.pvalid), 32'(m_tuser[0]));
				check_field("front_value", want.front, m_tdata[63:32]);
				check_field("back_value", want.back, m_tdata[95:64]);
				check_field("element_count", 32'(want.count), 32'(m_tdata[96 +: CW]));
				check_field("is_empty", 32'(want.empty), 32'(m_tuser[1]));
				check_field("overflow", 32'(want.ovf), 32'(m_tuser[2]));
				check_field("tdata padding", 32'h0, 32'(m_tdata >> (96 + CW)));
			end
		end
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// empty queue corners and the unused command codes
	task automatic test_empty_and_unused();
		send_request(CMD_LOOK, 32'h0);
		send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_POP_BACK, 32'h1234_5678);
		send_request(CMD_SPARE_5, 32'hDEAD_BEEF);
		send_request(CMD_SPARE_6, 32'h8000_0000);
		send_request(CMD_SPARE_7, 32'h7FFF_FFFF);
	endtask

	// both ends, extreme words, single-word queue
	task automatic test_end_access();
		send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
		send_request(CMD_PUSH_BACK, 32'h8000_0000);
		send_request(CMD_PUSH_FRONT, 32'h0000_0000);
		send_request(CMD_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(CMD_LOOK, 32'hA5A5_A5A5);
		send_request(CMD_SPARE_7, 32'h5A5A_5A5A);
		send_request(CMD_POP_FRONT, 32'h0);
		send_request(CMD_POP_BACK, 32'h0);
		send_request(CMD_POP_FRONT, 32'h0);
		send_request(CMD_POP_BACK, 32'h0);
		send_request(CMD_POP_BACK, 32'h0);
		send_request(CMD_PUSH_FRONT, 32'h0000_0005);
		send_request(CMD_POP_BACK, 32'h0);
		send_request(CMD_PUSH_BACK, 32'hFFFF_FFFB);
		send_request(CMD_POP_FRONT, 32'h0);
		send_request(CMD_POP_FRONT, 32'h0);
	endtask

	// fill to capacity under a long output hold-off, then push past full
	task automatic test_full_overflow();
		hold_req++;
		while (word_count < DEPTH)
			send_request(pick_push(), rand_word());
		send_request(CMD_PUSH_FRONT, 32'h1111_1111);
		send_request(CMD_PUSH_BACK, 32'h2222_2222);
		send_request(CMD_LOOK, 32'h0);
		send_request(CMD_SPARE_6, 32'h0);
		send_request(CMD_POP_FRONT, 32'h0);
		send_request(CMD_PUSH_BACK, 32'h8000_0000);
		send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
		send_request(CMD_POP_BACK, 32'h0);
		send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(CMD_PUSH_BACK, 32'h0);
	endtask

	// random segments, each leaning toward pushes, pops or neither
	task automatic test_random_mix();
		int seg_len;
		int push_pct;
		int r;
		while (sent_count < ITEM_BUDGET) begin
			seg_len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			no_idle = ($urandom_range(0, 5) == 0);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					send_request(3'($urandom_range(int'(CMD_LOOK), int'(CMD_SPARE_7))),
						rand_word());
				end else begin
					if ($urandom_range(0, 99) < push_pct)
						send_request(pick_push(), rand_word());
					else
						send_request(pick_pop(), rand_word());
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		head_pos       = 0;
		tail_pos       = 1 % DEPTH;
		word_count     = 0;
		sent_count     = 0;
		peak_count     = 0;
		hold_req       = 0;
		no_idle        = 1'b0;
		foreach (deque_words[i])
			deque_words[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unused();
		test_end_access();
		test_full_overflow();
		test_random_mix();
		s_tvalid <= 1'b0;

		// let every pending result come out, then let the clock run on idle before the report
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run covered %0d requests and %0d results, %0d words popped, %0d pushes dropped",
			sent_count, result_count, popped_count, overflow_count);
		$display("peak occupancy %0d of %0d words, %0d long output hold-offs",
			peak_count, DEPTH, holds_done);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
